// ===== hw/rtl/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared types and constants for the decoder front, queue and unit emitter.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD3_SURR = 8'hED;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;
  localparam logic [7:0] CONT_MIN   = 8'h80;
  localparam logic [7:0] CONT_MAX   = 8'hBF;
  localparam logic [7:0] E0_LOW     = 8'hA0;
  localparam logic [7:0] ED_HIGH    = 8'h9F;
  localparam logic [7:0] F0_LOW     = 8'h90;
  localparam logic [7:0] F4_HIGH    = 8'h8F;

  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [15:0] HIGH_SURR = 16'hD800;
  localparam logic [15:0] LOW_SURR  = 16'hDC00;

  typedef enum logic [1:0] {
    KIND_UNIT,
    KIND_PAIR,
    KIND_ERROR
  } kind_t;

  // One decoded item: a single unit, a supplementary code point less the
  // base offset, or an error.
  typedef struct packed {
    kind_t       kind;
    logic [19:0] data;
    logic        fin;
  } entry_t;

  typedef struct packed {
    logic [1:0]  pending;
    logic [20:0] partial;
    logic [7:0]  low_bound;
    logic [7:0]  high_bound;
    logic        at_second;
    logic        discarding;
  } front_state_t;

  localparam front_state_t FRONT_RESET = '{
    pending:    2'd0,
    partial:    21'd0,
    low_bound:  CONT_MIN,
    high_bound: CONT_MAX,
    at_second:  1'b0,
    discarding: 1'b0
  };

endpackage

// ===== hw/rtl/u8u16_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder front
// Validates each byte against the sequence in progress and pushes decoded
// code points or error markers into the queue.
// ----------------------------------------------------------------------------
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  byte_in,
  input  logic        end_of_string,
  output logic        push,
  output entry_t      entry
);

  front_state_t state;
  front_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FRONT_RESET;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic        ok;
    logic        done;
    logic [20:0] cp;
    logic [20:0] shifted;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [20:0] offset;
    ok         = 1'b1;
    done       = 1'b0;
    cp         = 21'd0;
    shifted    = {state.partial[14:0], byte_in[5:0]};
    lo         = state.at_second ? state.low_bound : CONT_MIN;
    hi         = state.at_second ? state.high_bound : CONT_MAX;
    offset     = 21'd0;
    state_next = state;
    push       = 1'b0;
    entry.kind = KIND_ERROR;
    entry.data = 20'd0;
    entry.fin  = end_of_string;
    if (accept) begin
      if (state.discarding) begin
        if (end_of_string) begin
          push       = 1'b1;
          state_next = FRONT_RESET;
        end
      end else begin
        if (state.pending == 2'd0) begin
          priority if (byte_in <= ASCII_MAX) begin
            cp   = {13'd0, byte_in};
            done = 1'b1;
          end else if (byte_in >= LEAD2_MIN && byte_in <= LEAD2_MAX) begin
            state_next.pending    = 2'd1;
            state_next.partial    = {16'd0, byte_in[4:0]};
            state_next.low_bound  = CONT_MIN;
            state_next.high_bound = CONT_MAX;
            state_next.at_second  = 1'b1;
          end else if (byte_in >= LEAD3_MIN && byte_in <= LEAD3_MAX) begin
            state_next.pending    = 2'd2;
            state_next.partial    = {17'd0, byte_in[3:0]};
            state_next.low_bound  = (byte_in == LEAD3_MIN) ? E0_LOW : CONT_MIN;
            state_next.high_bound = (byte_in == LEAD3_SURR) ? ED_HIGH : CONT_MAX;
            state_next.at_second  = 1'b1;
          end else if (byte_in >= LEAD4_MIN && byte_in <= LEAD4_MAX) begin
            state_next.pending    = 2'd3;
            state_next.partial    = {18'd0, byte_in[2:0]};
            state_next.low_bound  = (byte_in == LEAD4_MIN) ? F0_LOW : CONT_MIN;
            state_next.high_bound = (byte_in == LEAD4_MAX) ? F4_HIGH : CONT_MAX;
            state_next.at_second  = 1'b1;
          end else begin
            ok = 1'b0;
          end
        end else begin
          if (byte_in < lo || byte_in > hi) begin
            ok = 1'b0;
          end else begin
            state_next.partial   = shifted;
            state_next.pending   = state.pending - 2'd1;
            state_next.at_second = 1'b0;
            if (state.pending == 2'd1) begin
              cp                 = shifted;
              state_next.partial = 21'd0;
              done               = 1'b1;
            end
          end
        end

        if (!ok) begin
          push                  = 1'b1;
          state_next            = FRONT_RESET;
          state_next.discarding = !end_of_string;
        end else if (!done) begin
          if (end_of_string) begin
            push       = 1'b1;
            state_next = FRONT_RESET;
          end
        end else begin
          push   = 1'b1;
          offset = cp - SUPP_BASE;
          if (cp[20:16] != 5'd0) begin
            entry.kind = KIND_PAIR;
            entry.data = offset[19:0];
          end else begin
            entry.kind = KIND_UNIT;
            entry.data = {4'd0, cp[15:0]};
          end
          if (end_of_string) begin
            state_next = FRONT_RESET;
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/u8u16_fifo.sv =====
// ----------------------------------------------------------------------------
// Decoded item queue
// Short first-in first-out queue between the decoder front and the emitter.
// ----------------------------------------------------------------------------
module u8u16_fifo
  import u8u16_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  entry_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     count;

  assign empty = (count == '0);
  assign full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/u8u16_back.sv =====
// ----------------------------------------------------------------------------
// UTF-16 unit emitter
// Turns queued items into code units, splitting supplementary code points
// into a high and low surrogate over two beats, into an output register.
// ----------------------------------------------------------------------------
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  entry_t      head,
  input  logic        head_valid,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        bad_input,
  output logic        final_unit
);

  logic        low_half;
  logic        load;
  logic [15:0] unit_next;
  logic        bad_next;
  logic        fin_next;
  logic        low_half_next;

  assign load = head_valid && (!out_valid || out_ready);

  always_comb begin
    unit_next     = 16'd0;
    bad_next      = 1'b0;
    fin_next      = head.fin;
    low_half_next = low_half;
    pop           = 1'b0;
    unique case (head.kind)
      KIND_UNIT: begin
        unit_next = head.data[15:0];
        pop       = load;
      end
      KIND_PAIR: begin
        if (!low_half) begin
          unit_next = HIGH_SURR | {6'd0, head.data[19:10]};
          fin_next  = 1'b0;
          if (load) begin
            low_half_next = 1'b1;
          end
        end else begin
          unit_next = LOW_SURR | {6'd0, head.data[9:0]};
          pop       = load;
          if (load) begin
            low_half_next = 1'b0;
          end
        end
      end
      default: begin
        bad_next = 1'b1;
        pop      = load;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      low_half  <= 1'b0;
    end else begin
      low_half <= low_half_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_unit  <= unit_next;
      bad_input  <= bad_next;
      final_unit <= fin_next;
    end
  end

endmodule

// ===== hw/rtl/utf8_to_utf16_transcoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Strictly validating stream converter from UTF-8 bytes to UTF-16 units.
// ----------------------------------------------------------------------------
// The slave stream carries one UTF-8 byte per beat, with tlast on the final
// byte of a string. The master stream carries one UTF-16 code unit per beat,
// with tuser high for an error result and tlast on the last result of a
// string. After an error, later bytes of the string are dropped and the final
// byte gives a closing error beat.
// A byte enters on any cycle in which tready is high, one per cycle. The
// decoder front works within the cycle of acceptance; each decoded item is
// then registered in the queue and after that in the output register before
// it is valid on the master side. A supplementary code point gives two beats,
// a high and then a low surrogate, and the emitter keeps its queue entry
// until it loads the low surrogate; a four-entry queue between front and
// emitter absorbs this and any stall.
// When the receiver holds tready low the output beat holds, the queue fills,
// and tready on the slave side falls once the queue is full.
// A synchronous reset empties the queue and the output register and returns
// the decoder to the start of a string.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic        m_axis_tuser,   // [0] bad_input
  output logic        m_axis_tlast
);

  logic   accept;
  logic   push;
  entry_t push_entry;
  logic   pop;
  entry_t head;
  logic   empty;
  logic   full;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  u8u16_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .byte_in       (s_axis_tdata),
    .end_of_string (s_axis_tlast),
    .push          (push),
    .entry         (push_entry)
  );

  u8u16_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!empty),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .code_unit  (m_axis_tdata),
    .bad_input  (m_axis_tuser),
    .final_unit (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/u8u16_checker.sv =====
// ----------------------------------------------------------------------------
// Transcoder port checker
// Concurrent checks on the top level's stream ports, bound to the top level.
// ----------------------------------------------------------------------------
module u8u16_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("Output beat changed while stalled.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("Output beat present after reset.");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> s_axis_tready)
    else $error("Byte stream not ready after reset.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("Error beat carries a non-zero code unit.");

  a_high_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser && m_axis_tdata[15:10] == 6'b110110
      |-> !m_axis_tlast)
    else $error("High surrogate marked as the last unit of a string.");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
